// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked out of reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen out of reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// File: rtl/clnw_pkg.sv
// Types and constants for the character LCD nibble writer.
// No dependencies; used by the top level and its checker.
package clnw_pkg;

  typedef logic [2:0] func_t;
  typedef logic [1:0] row_t;
  typedef logic [5:0] column_t;

  localparam func_t FUNC_CMD         = 3'd0;
  localparam func_t FUNC_DATA        = 3'd1;
  localparam func_t FUNC_DATA_AT_POS = 3'd2;
  localparam func_t FUNC_NUM         = 3'd3;
  localparam func_t FUNC_NUM_AT_POS  = 3'd4;

  localparam row_t ROW_FIRST  = 2'd1;
  localparam row_t ROW_SECOND = 2'd2;

  localparam logic [7:0] CURSOR_BASE_ROW1 = 8'h80;
  localparam logic [7:0] CURSOR_BASE_ROW2 = 8'hC0;
  localparam logic [7:0] ASCII_ZERO       = 8'h30;

  // floor(n / 10) == (n * DIV10_RECIP) >> DIV10_SHIFT for every 32-bit n
  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

endpackage

// File: rtl/char_lcd_nibble_writer.sv
// Character LCD 4-bit write controller: bytes, cursor moves and decimal numbers.
// Depends on clnw_pkg.
// A byte request is accepted, then its first nibble is registered into the output; a number
//   has each digit made in the shared divide-by-ten unit (multiply, then
//   remainder) before its first nibble.
// Throughput: one nibble per cycle while the sink is ready; s_axis_tready returns as
//   soon as the final nibble sits in the output register (up to 22 nibbles per word).
// Reset: synchronous, active high; clears the sequencer and output valid.
module char_lcd_nibble_writer #(
  parameter int MAX_DIGITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // value[31:0], row[33:32], column[39:34]
  input  clnw_pkg::func_t s_axis_tuser,  // func[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // nibble[3:0], zero[7:4]
  output logic        m_axis_tuser,  // reg_select[0]
  output logic        m_axis_tlast
);
  import clnw_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]       state;
  logic [7:0]       byte_val;
  logic             byte_rs;
  row_t             row;
  column_t          column;
  logic [31:0]      num;
  logic [28:0]      quo;
  logic [3:0]       digits [MAX_DIGITS];
  logic [CNT_W-1:0] cnt;
  logic             hi_phase;
  logic             cursor_pend;
  logic             numeric;
  logic [3:0]       nib;
  logic             rs;
  logic             last;

  logic [63:0]      mul_full;
  logic [32:0]      quo_x10;
  logic [31:0]      rem_full;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] digit_idx;
  logic [7:0]       cursor_byte;
  logic [7:0]       cur_byte;
  logic             cur_rs;
  logic             cur_last;
  logic             out_free;
  logic             in_fire;
  func_t            in_func;
  row_t             in_row;

  assign in_func = s_axis_tuser;
  assign in_row  = s_axis_tdata[33:32];
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Shared divide-by-ten unit: reciprocal multiply, then remainder
  assign mul_full = {32'b0, num} * {32'b0, DIV10_RECIP};
  assign quo_x10  = {1'b0, quo, 3'b000} + {3'b000, quo, 1'b0};
  assign rem_full = num - quo_x10[31:0];

  assign cnt_m1    = cnt - CNT_W'(1);
  assign digit_idx = cnt_m1[IDX_W-1:0];

  assign cursor_byte = ((row == ROW_FIRST) ? CURSOR_BASE_ROW1 : CURSOR_BASE_ROW2)
                       + {2'b00, column} - 8'd1;

  always_comb begin
    if (cursor_pend) begin
      cur_byte = cursor_byte;
      cur_rs   = RS_CMD;
    end else if (numeric) begin
      cur_byte = ASCII_ZERO | {4'b0000, digits[digit_idx]};
      cur_rs   = RS_DATA;
    end else begin
      cur_byte = byte_val;
      cur_rs   = byte_rs;
    end
    cur_last = !hi_phase && !cursor_pend && (!numeric || cnt == CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == S_EMIT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire && in_func <= FUNC_NUM_AT_POS) begin
            numeric     <= (in_func == FUNC_NUM) || (in_func == FUNC_NUM_AT_POS);
            cursor_pend <= ((in_func == FUNC_DATA_AT_POS) || (in_func == FUNC_NUM_AT_POS))
                           && ((in_row == ROW_FIRST) || (in_row == ROW_SECOND));
            byte_rs     <= (in_func == FUNC_CMD) ? RS_CMD : RS_DATA;
            byte_val    <= s_axis_tdata[7:0];
            num         <= s_axis_tdata[31:0];
            row         <= in_row;
            column      <= s_axis_tdata[39:34];
            hi_phase    <= 1'b1;
            cnt         <= '0;
            state       <= ((in_func == FUNC_NUM) || (in_func == FUNC_NUM_AT_POS))
                           ? S_MUL : S_EMIT;
          end
        end
        S_MUL: begin
          quo   <= mul_full[63:DIV10_SHIFT];
          state <= S_DIV;
        end
        S_DIV: begin
          digits[cnt[IDX_W-1:0]] <= rem_full[3:0];
          num <= {3'b000, quo};
          cnt <= cnt + CNT_W'(1);
          // stop on the last digit or when the digit store is full
          if (quo == '0 || cnt == CNT_W'(MAX_DIGITS - 1)) begin
            state <= S_EMIT;
          end else begin
            state <= S_MUL;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            nib  <= hi_phase ? cur_byte[7:4] : cur_byte[3:0];
            rs   <= cur_rs;
            last <= cur_last;
            hi_phase <= !hi_phase;
            if (!hi_phase) begin
              if (cursor_pend) begin
                cursor_pend <= 1'b0;
              end else if (numeric) begin
                cnt <= cnt_m1;
              end
            end
            if (cur_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = {4'b0000, nib};
  assign m_axis_tuser = rs;
  assign m_axis_tlast = last;

endmodule

// File: rtl/clnw_checker.sv
// Port-level checker for the character LCD nibble writer, bound to the top level.
// Depends on clnw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module clnw_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [39:0] s_axis_tdata,
  input clnw_pkg::func_t s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);
  import clnw_pkg::*;

  logic in_fire;
  logic stalled;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign stalled = m_axis_tvalid && !m_axis_tready;

  // hold a stalled output word
  `ASSERT_PROP(a_out_hold, clk, rst, stalled |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output word changed while stalled")

  // a valid request keeps the block busy for at least the next cycle
  `ASSERT_PROP(a_busy_after_req, clk, rst, in_fire && (s_axis_tuser <= FUNC_NUM_AT_POS) |=> !s_axis_tready, "ready right after a valid request")

  // an unused code is dropped at once
  `ASSERT_PROP(a_drop_bad_func, clk, rst, in_fire && (s_axis_tuser > FUNC_NUM_AT_POS) |=> s_axis_tready && !($rose(m_axis_tvalid)), "unused func code produced work")

  // no new request while a request still has nibbles to send
  `ASSERT_NEVER(a_no_overlap, clk, rst, m_axis_tvalid && !m_axis_tlast && s_axis_tready, "ready in the middle of a request")

endmodule

bind char_lcd_nibble_writer clnw_checker u_clnw_checker (.*);
